// File: design/lpmr_pkg.sv
package lpmr_pkg;

	localparam int FEEDBACK_CLEAR_PERIOD_DEF = 560;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int SEED_W     = 7;

	// register index taken from paddr[2]
	localparam logic REG_RANDOM_SEED = 1'b0;

	localparam logic [SEED_W-1:0] SEED_RESET = 7'b1110011;

	localparam logic [7:0] SNAKE_BODY = 8'b0000_0111;
	localparam logic [7:0] QUEUE_TOP  = 8'b1000_0000;
	localparam logic [7:0] COUNT_MAX  = 8'd255;
	localparam logic [3:0] DIGIT_MAX  = 4'd9;
	localparam logic [3:0] SNAKE_TURN = 4'd5;
	localparam logic [2:0] SNAKE_END  = 3'd5;

	localparam logic [3:0] PAT_IDLE    = 4'd0;
	localparam logic [3:0] PAT_BIN_UP  = 4'd1;
	localparam logic [3:0] PAT_BIN_DN  = 4'd2;
	localparam logic [3:0] PAT_GRAY_UP = 4'd3;
	localparam logic [3:0] PAT_GRAY_DN = 4'd4;
	localparam logic [3:0] PAT_BCD_UP  = 4'd5;
	localparam logic [3:0] PAT_BCD_DN  = 4'd6;
	localparam logic [3:0] PAT_SNAKE   = 4'd7;
	localparam logic [3:0] PAT_QUEUE   = 4'd8;
	localparam logic [3:0] PAT_RANDOM  = 4'd9;

	typedef enum logic [9:0] {
		M_IDLE    = 10'b00_0000_0001,
		M_BIN_UP  = 10'b00_0000_0010,
		M_BIN_DN  = 10'b00_0000_0100,
		M_GRAY_UP = 10'b00_0000_1000,
		M_GRAY_DN = 10'b00_0001_0000,
		M_BCD_UP  = 10'b00_0010_0000,
		M_BCD_DN  = 10'b00_0100_0000,
		M_SNAKE   = 10'b00_1000_0000,
		M_QUEUE   = 10'b01_0000_0000,
		M_RANDOM  = 10'b10_0000_0000
	} mode_t;

	typedef struct packed {
		logic [7:0] leds;
		logic [3:0] pattern;
	} result_t;

	function automatic logic [3:0] mode_num(mode_t m);
		logic [3:0] r;
		unique case (m)
			M_BIN_UP:  r = PAT_BIN_UP;
			M_BIN_DN:  r = PAT_BIN_DN;
			M_GRAY_UP: r = PAT_GRAY_UP;
			M_GRAY_DN: r = PAT_GRAY_DN;
			M_BCD_UP:  r = PAT_BCD_UP;
			M_BCD_DN:  r = PAT_BCD_DN;
			M_SNAKE:   r = PAT_SNAKE;
			M_QUEUE:   r = PAT_QUEUE;
			M_RANDOM:  r = PAT_RANDOM;
			default:   r = PAT_IDLE;
		endcase
		return r;
	endfunction

	function automatic mode_t mode_next(mode_t m);
		mode_t r;
		unique case (m)
			M_BIN_UP:  r = M_BIN_DN;
			M_BIN_DN:  r = M_GRAY_UP;
			M_GRAY_UP: r = M_GRAY_DN;
			M_GRAY_DN: r = M_BCD_UP;
			M_BCD_UP:  r = M_BCD_DN;
			M_BCD_DN:  r = M_SNAKE;
			M_SNAKE:   r = M_QUEUE;
			M_QUEUE:   r = M_RANDOM;
			M_RANDOM:  r = M_BIN_UP;
			default:   r = M_IDLE;
		endcase
		return r;
	endfunction

	function automatic mode_t mode_prev(mode_t m);
		mode_t r;
		unique case (m)
			M_BIN_UP:  r = M_RANDOM;
			M_BIN_DN:  r = M_BIN_UP;
			M_GRAY_UP: r = M_BIN_DN;
			M_GRAY_DN: r = M_GRAY_UP;
			M_BCD_UP:  r = M_GRAY_DN;
			M_BCD_DN:  r = M_BCD_UP;
			M_SNAKE:   r = M_BCD_DN;
			M_QUEUE:   r = M_SNAKE;
			M_RANDOM:  r = M_QUEUE;
			default:   r = M_IDLE;
		endcase
		return r;
	endfunction

endpackage

// File: design/lpmr_in_if.sv
interface lpmr_in_if;
	logic valid;
	logic ready;
	logic prev_button_level;
	logic next_button_level;

	modport source (output valid, output prev_button_level, output next_button_level,
		input ready);
	modport sink (input valid, input prev_button_level, input next_button_level,
		output ready);
endinterface

// File: design/lpmr_out_if.sv
interface lpmr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] leds;
	logic [3:0] pattern;

	modport source (output valid, output leds, output pattern, input ready);
	modport sink (input valid, input leds, input pattern, output ready);
endinterface

// File: design/lpmr_cfg.sv
module lpmr_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lpmr_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [lpmr_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [lpmr_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                              pready,
	output logic [lpmr_pkg::SEED_W-1:0]      seed
);
	import lpmr_pkg::*;

	logic [SEED_W-1:0] seed_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign seed   = seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (wr_en && paddr[2] == REG_RANDOM_SEED) begin
			seed_q <= pwdata[SEED_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_RANDOM_SEED) begin
			prdata = {{(CFG_DATA_W-SEED_W){1'b0}}, seed_q};
		end
	end
endmodule

// File: design/lpmr_core.sv
module lpmr_core #(
	parameter int FEEDBACK_CLEAR_PERIOD = lpmr_pkg::FEEDBACK_CLEAR_PERIOD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          prev_level,
	input  logic                          next_level,
	input  logic [lpmr_pkg::SEED_W-1:0]  seed,
	output lpmr_pkg::result_t             res
);
	import lpmr_pkg::*;

	localparam int RC_W = $clog2(FEEDBACK_CLEAR_PERIOD + 1);

	mode_t             mode_q, mode_n;
	logic              last_p_q, last_n_q;
	logic [7:0]        count_q, count_n;
	logic [3:0]        tens_q, tens_n, units_q, units_n;
	logic [2:0]        pos_q, pos_n;
	logic [3:0]        step_q, step_n;
	logic [7:0]        filled_q, filled_n, moving_q, moving_n;
	logic [SEED_W-1:0] sr_q, sr_n;
	logic              fb_q, fb_n;
	logic [2:0]        tap_q, tap_n;
	logic [RC_W-1:0]   rc_q, rc_n, rc_inc;
	logic [7:0]        leds_c;
	logic [7:0]        sr_ext;
	logic [3:0]        tens_e, units_e, step_e;
	logic [2:0]        pos_e;
	logic [3:0]        cur_pat;
	logic              p_rise, n_rise, p_fall, n_fall, prev_first, go_back;
	logic              enter;
	mode_t             target;

	assign cur_pat = mode_num(mode_q);
	assign sr_ext  = {1'b0, sr_q};
	assign rc_inc  = rc_q + 1'b1;

	assign p_rise = !last_p_q && prev_level;
	assign n_rise = !last_n_q && next_level;
	assign p_fall = last_p_q && !prev_level;
	assign n_fall = last_n_q && !next_level;
	assign prev_first = mode_q == M_BIN_UP || mode_q == M_QUEUE || mode_q == M_RANDOM;
	assign go_back = p_fall && (prev_first || !n_fall);

	// mode change after this tick, chosen from the button edges
	always_comb begin
		enter  = 1'b0;
		target = M_IDLE;
		if (cur_pat == PAT_IDLE) begin
			if (p_rise) begin
				enter  = 1'b1;
				target = M_BIN_DN;
			end else if (n_rise) begin
				enter  = 1'b1;
				target = M_BIN_UP;
			end
		end else if (p_fall || n_fall) begin
			enter  = 1'b1;
			target = go_back ? mode_prev(mode_q) : mode_next(mode_q);
		end
	end

	always_comb begin
		mode_n   = mode_q;
		count_n  = count_q;
		tens_n   = tens_q;
		units_n  = units_q;
		pos_n    = pos_q;
		step_n   = step_q;
		filled_n = filled_q;
		moving_n = moving_q;
		sr_n     = sr_q;
		fb_n     = fb_q;
		tap_n    = tap_q;
		rc_n     = rc_q;
		leds_c   = '0;
		tens_e   = tens_q;
		units_e  = units_q;
		step_e   = step_q;
		pos_e    = pos_q;

		case (mode_q)
			M_BIN_UP: begin
				leds_c  = count_q;
				count_n = count_q + 1'b1;
			end
			M_BIN_DN: begin
				leds_c  = count_q;
				count_n = count_q - 1'b1;
			end
			M_GRAY_UP: begin
				leds_c  = count_q ^ (count_q >> 1);
				count_n = count_q + 1'b1;
			end
			M_GRAY_DN: begin
				leds_c  = count_q ^ (count_q >> 1);
				count_n = count_q - 1'b1;
			end
			M_BCD_UP: begin
				if (tens_q > DIGIT_MAX || units_q > DIGIT_MAX) begin
					tens_e  = '0;
					units_e = '0;
				end
				leds_c = {tens_e, units_e};
				if (units_e == DIGIT_MAX) begin
					units_n = '0;
					tens_n  = (tens_e == DIGIT_MAX) ? 4'd0 : tens_e + 1'b1;
				end else begin
					units_n = units_e + 1'b1;
					tens_n  = tens_e;
				end
			end
			M_BCD_DN: begin
				if (tens_q > DIGIT_MAX || units_q > DIGIT_MAX) begin
					tens_e  = DIGIT_MAX;
					units_e = DIGIT_MAX;
				end
				leds_c = {tens_e, units_e};
				if (units_e == 4'd0) begin
					units_n = DIGIT_MAX;
					tens_n  = (tens_e == 4'd0) ? DIGIT_MAX : tens_e - 1'b1;
				end else begin
					units_n = units_e - 1'b1;
					tens_n  = tens_e;
				end
			end
			M_SNAKE: begin
				if (step_q > DIGIT_MAX || pos_q > SNAKE_END) begin
					step_e = '0;
					pos_e  = '0;
				end
				leds_c = SNAKE_BODY << pos_e;
				pos_n  = (step_e < SNAKE_TURN) ? pos_e + 1'b1 : pos_e - 1'b1;
				step_n = (step_e == DIGIT_MAX) ? 4'd0 : step_e + 1'b1;
			end
			M_QUEUE: begin
				// lit bit lands on the top or on a filled bit
				if (|(filled_q & {moving_q[6:0], 1'b0}) || moving_q == QUEUE_TOP) begin
					filled_n = filled_q | moving_q;
					leds_c   = filled_n;
					moving_n = 8'd1;
				end else begin
					leds_c   = filled_q | moving_q;
					moving_n = {moving_q[6:0], 1'b0};
				end
				if (filled_n == COUNT_MAX) begin
					filled_n = '0;
				end
			end
			M_RANDOM: begin
				leds_c = {1'b0, sr_q};
				fb_n   = fb_q ^ sr_ext[tap_q];
				sr_n   = {fb_n, sr_q[SEED_W-1:1]};
				tap_n  = tap_q + 1'b1;
				rc_n   = rc_inc;
				if (rc_inc >= RC_W'(FEEDBACK_CLEAR_PERIOD)) begin
					rc_n  = '0;
					fb_n  = 1'b0;
					tap_n = '0;
				end
			end
			default: begin
				leds_c = '0;
			end
		endcase

		if (enter) begin
			mode_n   = target;
			count_n  = (target == M_BIN_DN || target == M_GRAY_DN) ? COUNT_MAX : 8'd0;
			tens_n   = (target == M_BCD_DN) ? DIGIT_MAX : 4'd0;
			units_n  = (target == M_BCD_DN) ? DIGIT_MAX : 4'd0;
			pos_n    = '0;
			step_n   = '0;
			filled_n = '0;
			moving_n = 8'd1;
			sr_n     = seed;
			fb_n     = 1'b0;
			tap_n    = '0;
			rc_n     = '0;
		end
	end

	assign res.leds    = leds_c;
	assign res.pattern = cur_pat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			last_p_q <= 1'b0;
			last_n_q <= 1'b0;
			count_q  <= '0;
			tens_q   <= '0;
			units_q  <= '0;
			pos_q    <= '0;
			step_q   <= '0;
			filled_q <= '0;
			moving_q <= 8'd1;
			sr_q     <= SEED_RESET;
			fb_q     <= 1'b0;
			tap_q    <= '0;
			rc_q     <= '0;
		end else if (accept) begin
			mode_q   <= mode_n;
			last_p_q <= prev_level;
			last_n_q <= next_level;
			count_q  <= count_n;
			tens_q   <= tens_n;
			units_q  <= units_n;
			pos_q    <= pos_n;
			step_q   <= step_n;
			filled_q <= filled_n;
			moving_q <= moving_n;
			sr_q     <= sr_n;
			fb_q     <= fb_n;
			tap_q    <= tap_n;
			rc_q     <= rc_n;
		end
	end

	// idle with no rising edge stays idle
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cur_pat == PAT_IDLE && !p_rise && !n_rise |=> cur_pat == PAT_IDLE)
		else $error("idle left without a rising edge");

	// running pattern without a press keeps its mode
	a_mode_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cur_pat != PAT_IDLE && !p_fall && !n_fall |=> $stable(mode_q))
		else $error("mode changed without a press");
endmodule

// File: design/led_pattern_mode_ring.sv
// latency: the result of a tick transfer is registered and presented in the cycle after it is accepted
// throughput: one tick per cycle while the output is not stalled; all pattern state updates go
// through the core state registers, input stalls only while a result is unread
// reset (arst_n low, asynchronous): idle mode, last button levels 0, seed 115,
// output register empty
module led_pattern_mode_ring #(
	parameter int FEEDBACK_CLEAR_PERIOD = lpmr_pkg::FEEDBACK_CLEAR_PERIOD_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	lpmr_in_if.sink                           in_ch,
	lpmr_out_if.source                        out_ch,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lpmr_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [lpmr_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [lpmr_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                              pready
);
	import lpmr_pkg::*;

	logic              out_valid_q;
	result_t           res_c, res_q;
	logic              accept;
	logic [SEED_W-1:0] seed;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	lpmr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.seed    (seed)
	);

	lpmr_core #(
		.FEEDBACK_CLEAR_PERIOD(FEEDBACK_CLEAR_PERIOD)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.prev_level (in_ch.prev_button_level),
		.next_level (in_ch.next_button_level),
		.seed       (seed),
		.res        (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_c;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.leds    = res_q.leds;
	assign out_ch.pattern = res_q.pattern;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted tick produced no result");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |-> !in_ch.ready)
		else $error("tick taken while result is stalled");

	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ch.pattern == PAT_IDLE |-> out_ch.leds == 8'd0)
		else $error("leds lit while idle");
endmodule

// File: tb/sv/led_pattern_mode_ring_test.sv
module led_pattern_mode_ring_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lpmr_pkg::*;

	localparam int unsigned ITEM_TARGET = 1150;
	localparam int unsigned TAIL_ITEMS  = 150;
	localparam int unsigned PHASE_ITEMS = 120;
	localparam int unsigned LONG_HOLD   = 80;
	localparam int unsigned WATCHDOG    = 2000;

	localparam logic [CFG_ADDR_W-1:0] SEED_ADDR   = {REG_RANDOM_SEED, 2'b00};
	localparam logic [CFG_ADDR_W-1:0] UNUSED_ADDR = {~REG_RANDOM_SEED, 2'b00};

	typedef struct {
		logic       prev_lvl;
		logic       next_lvl;
		bit         typed;
		logic [7:0] leds;
		logic [3:0] pattern;
	} tick_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	lpmr_in_if  in_ch ();
	lpmr_out_if out_ch ();

	led_pattern_mode_ring dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [SEED_W-1:0] seed_cfg;
	logic [3:0] ring_mode;
	logic last_prev, last_next;
	logic [7:0] ring_count;
	logic [3:0] bcd_tens, bcd_units;
	logic [2:0] snake_pos;
	logic [3:0] snake_stp;
	logic [7:0] stack_filled, stack_moving;
	logic [6:0] lfsr;
	logic fb;
	logic [2:0] tap;
	logic [9:0] since_clear;

	result_t due_results[$];
	int unsigned failures = 0;
	int unsigned sent = 0;
	int unsigned ticks_taken = 0;
	int unsigned quiet = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;
	bit long_hold_req = 0;
	bit cur_typed = 0;
	result_t cur_want;

	function automatic void enter_pattern(logic [3:0] m);
		ring_mode = m;
		ring_count = (m == PAT_BIN_DN || m == PAT_GRAY_DN) ? COUNT_MAX : 8'd0;
		bcd_tens = (m == PAT_BCD_DN) ? DIGIT_MAX : 4'd0;
		bcd_units = bcd_tens;
		snake_pos = '0;
		snake_stp = '0;
		stack_filled = '0;
		stack_moving = 8'd1;
		lfsr = seed_cfg;
		fb = 1'b0;
		tap = '0;
		since_clear = '0;
	endfunction

	// one display tick: show, advance, then look at the button edges
	function automatic result_t led_tick(logic p, logic n);
		result_t r;
		logic p_fall, n_fall, back;
		logic [3:0] shown_pat, dest;
		logic [7:0] lfsr_ext;
		shown_pat = ring_mode;
		r.pattern = ring_mode;
		r.leds = '0;
		case (ring_mode)
			PAT_BIN_UP, PAT_BIN_DN: begin
				r.leds = ring_count;
				ring_count = (ring_mode == PAT_BIN_UP) ? ring_count + 8'd1 : ring_count - 8'd1;
			end
			PAT_GRAY_UP, PAT_GRAY_DN: begin
				r.leds = ring_count ^ (ring_count >> 1);
				ring_count = (ring_mode == PAT_GRAY_UP) ? ring_count + 8'd1 : ring_count - 8'd1;
			end
			PAT_BCD_UP: begin
				r.leds = {bcd_tens, bcd_units};
				if (bcd_units == DIGIT_MAX) begin
					bcd_units = '0;
					bcd_tens = (bcd_tens == DIGIT_MAX) ? 4'd0 : bcd_tens + 4'd1;
				end else
					bcd_units = bcd_units + 4'd1;
			end
			PAT_BCD_DN: begin
				r.leds = {bcd_tens, bcd_units};
				if (bcd_units == 4'd0) begin
					bcd_units = DIGIT_MAX;
					bcd_tens = (bcd_tens == 4'd0) ? DIGIT_MAX : bcd_tens - 4'd1;
				end else
					bcd_units = bcd_units - 4'd1;
			end
			PAT_SNAKE: begin
				r.leds = SNAKE_BODY << snake_pos;
				if (snake_stp < SNAKE_TURN)
					snake_pos = snake_pos + 3'd1;
				else
					snake_pos = snake_pos - 3'd1;
				snake_stp = snake_stp + 4'd1;
				if (snake_stp == 4'd10)
					snake_stp = '0;
			end
			PAT_QUEUE: begin
				// the lit bit lands on the filled stack or on the top bit
				if ((stack_filled & {stack_moving[6:0], 1'b0}) != 8'd0 ||
						stack_moving == QUEUE_TOP) begin
					stack_filled = stack_filled | stack_moving;
					r.leds = stack_filled;
					stack_moving = 8'd1;
				end else begin
					r.leds = stack_filled | stack_moving;
					stack_moving = {stack_moving[6:0], 1'b0};
				end
				if (stack_filled == COUNT_MAX)
					stack_filled = '0;
			end
			PAT_RANDOM: begin
				r.leds = {1'b0, lfsr};
				// tap 7 reads above the register and sees a zero
				lfsr_ext = {1'b0, lfsr};
				fb = fb ^ lfsr_ext[tap];
				lfsr = {fb, lfsr[6:1]};
				tap = tap + 3'd1;
				since_clear = since_clear + 10'd1;
				if (since_clear >= FEEDBACK_CLEAR_PERIOD_DEF) begin
					since_clear = '0;
					fb = 1'b0;
					tap = '0;
				end
			end
			default: r.leds = '0;
		endcase

		p_fall = last_prev & ~p;
		n_fall = last_next & ~n;
		if (shown_pat == PAT_IDLE) begin
			if (!last_prev && p)
				enter_pattern(PAT_BIN_DN);
			else if (!last_next && n)
				enter_pattern(PAT_BIN_UP);
		end else if (p_fall || n_fall) begin
			// on a double press the previous button wins only in these three
			back = p_fall && (shown_pat == PAT_BIN_UP || shown_pat == PAT_QUEUE ||
				shown_pat == PAT_RANDOM || !n_fall);
			if (back)
				dest = (shown_pat == PAT_BIN_UP) ? PAT_RANDOM : shown_pat - 4'd1;
			else
				dest = (shown_pat == PAT_RANDOM) ? PAT_BIN_UP : shown_pat + 4'd1;
			enter_pattern(dest);
		end
		last_prev = p;
		last_next = n;
		return r;
	endfunction

	// transfers are sampled here, results first, then the tick that goes in
	always @(posedge clk) begin : watch
		result_t want;
		bit moved;
		moved = 0;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				moved = 1;
				if (due_results.size() == 0) begin
					$error("unexpected result: leds %02h pattern %0d", out_ch.leds, out_ch.pattern);
					failures++;
				end else begin
					want = due_results.pop_front();
					if (out_ch.leds !== want.leds) begin
						$error("leds: expected %02h, got %02h", want.leds, out_ch.leds);
						failures++;
					end
					if (out_ch.pattern !== want.pattern) begin
						$error("pattern: expected %0d, got %0d", want.pattern, out_ch.pattern);
						failures++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				moved = 1;
				want = led_tick(in_ch.prev_button_level, in_ch.next_button_level);
				if (cur_typed)
					want = cur_want;
				due_results.push_back(want);
				ticks_taken++;
			end
			quiet = moved ? 0 : quiet + 1;
			if (quiet >= WATCHDOG) begin
				$display("led_pattern_mode_ring_test NOT OK");
				$finish;
			end
		end
	end

	initial begin : sink_side
		int unsigned hold_left;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				hold_left = LONG_HOLD;
				long_hold_req = 0;
			end else if (hold_left == 0 && $urandom_range(99) < sink_idle_pct)
				hold_left = $urandom_range(5, 1);
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready = 1'b0;
			end else
				out_ch.ready = 1'b1;
		end
	end

	task automatic send_tick(logic p, logic n, bit typed = 0, result_t want = '0);
		int unsigned gap, start;
		gap = 0;
		if ($urandom_range(99) < src_idle_pct)
			gap = $urandom_range(5, 1);
		if (gap != 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cur_typed = typed;
		cur_want = want;
		in_ch.prev_button_level = p;
		in_ch.next_button_level = n;
		in_ch.valid = 1'b1;
		start = ticks_taken;
		do
			@(negedge clk);
		while (ticks_taken == start);
		sent++;
	endtask

	task automatic drain();
		in_ch.valid = 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (addr[2] == REG_RANDOM_SEED)
			seed_cfg = data[SEED_W-1:0];
	endtask

	task automatic press(bit on_prev, bit on_next);
		send_tick(!on_prev, !on_next);
		send_tick(1'b1, 1'b1);
	endtask

	task automatic steer_to_random();
		int hops;
		send_tick(1'b1, 1'b1);
		hops = int'(PAT_RANDOM) - int'(ring_mode);
		repeat (hops) press(1'b0, 1'b1);
	endtask

	task automatic ring_segment();
		int unsigned pick, dwell;
		logic hp, hn;
		pick = $urandom_range(99);
		if (pick < 80) begin
			pick = $urandom_range(99);
			if (pick < 70)
				dwell = $urandom_range(12, 1);
			else if (pick < 95)
				dwell = $urandom_range(110, 13);
			else
				dwell = $urandom_range(300, 200);
			repeat (dwell) send_tick(1'b1, 1'b1);
			// prev alone, next alone, both together, or prev then next
			pick = $urandom_range(3);
			hp = (pick == 1);
			hn = (pick == 0);
			if (pick == 3)
				send_tick(1'b0, 1'b1);
			repeat ($urandom_range(3, 1)) send_tick(hp, hn);
			send_tick(1'b1, 1'b1);
		end else
			repeat ($urandom_range(8, 1))
				send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	function automatic int unsigned pick_idle_pct();
		case ($urandom_range(2))
			0: return 0;
			1: return 12;
			default: return 35;
		endcase
	endfunction

	tick_row_t script [26] = '{
		'{1'b0, 1'b0, 1, 8'h00, PAT_IDLE},
		'{1'b0, 1'b0, 1, 8'h00, PAT_IDLE},
		'{1'b1, 1'b1, 1, 8'h00, PAT_IDLE},
		'{1'b1, 1'b1, 1, 8'hFF, PAT_BIN_DN},
		'{1'b1, 1'b1, 1, 8'hFE, PAT_BIN_DN},
		'{1'b1, 1'b0, 1, 8'hFD, PAT_BIN_DN},
		'{1'b1, 1'b1, 1, 8'h00, PAT_GRAY_UP},
		'{1'b1, 1'b1, 1, 8'h01, PAT_GRAY_UP},
		'{1'b0, 1'b0, 1, 8'h03, PAT_GRAY_UP},
		'{1'b1, 1'b1, 1, 8'h80, PAT_GRAY_DN},
		'{1'b1, 1'b0, 1, 8'h81, PAT_GRAY_DN},
		'{1'b1, 1'b1, 1, 8'h00, PAT_BCD_UP},
		'{1'b1, 1'b0, 1, 8'h01, PAT_BCD_UP},
		'{1'b1, 1'b1, 1, 8'h99, PAT_BCD_DN},
		'{1'b1, 1'b0, 1, 8'h98, PAT_BCD_DN},
		'{1'b1, 1'b1, 1, 8'h07, PAT_SNAKE},
		'{1'b1, 1'b0, 1, 8'h0E, PAT_SNAKE},
		'{1'b1, 1'b1, 1, 8'h01, PAT_QUEUE},
		'{1'b0, 1'b0, 1, 8'h02, PAT_QUEUE},
		'{1'b1, 1'b1, 1, 8'h07, PAT_SNAKE},
		'{1'b1, 1'b0, 1, 8'h0E, PAT_SNAKE},
		'{1'b1, 1'b1, 1, 8'h01, PAT_QUEUE},
		'{1'b1, 1'b0, 1, 8'h02, PAT_QUEUE},
		'{1'b1, 1'b1, 1, 8'h73, PAT_RANDOM},
		'{1'b0, 1'b0, 0, 8'h00, PAT_RANDOM},
		'{1'b1, 1'b1, 1, 8'h01, PAT_QUEUE}
	};

	initial begin : stimulus
		int unsigned phase_start;
		bit paused;
		logic [SEED_W-1:0] seed;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.prev_button_level = 1'b0;
		in_ch.next_button_level = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		seed_cfg = SEED_RESET;
		enter_pattern(PAT_IDLE);
		last_prev = 1'b0;
		last_next = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		src_idle_pct = 20;
		sink_idle_pct = 20;
		foreach (script[i])
			send_tick(script[i].prev_lvl, script[i].next_lvl, script[i].typed,
				'{leds: script[i].leds, pattern: script[i].pattern});

		// all-zero seed keeps the shift register dark
		drain();
		cfg_write(SEED_ADDR, {25'($urandom), 7'h00});
		steer_to_random();
		repeat (20) send_tick(1'b1, 1'b1);

		drain();
		cfg_write(UNUSED_ADDR, $urandom);
		cfg_write(SEED_ADDR, {25'($urandom), 7'h7F});
		press(1'b0, 1'b1);
		press(1'b1, 1'b0);
		for (int i = 0; i < 280; i++) begin
			if (i == 100)
				long_hold_req = 1;
			send_tick(1'b1, 1'b1);
		end

		// a new seed must not disturb the running random pattern
		drain();
		cfg_write(SEED_ADDR, $urandom);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		repeat (320) send_tick(1'b1, 1'b1);

		while (sent < ITEM_TARGET - TAIL_ITEMS) begin
			drain();
			if ($urandom_range(3) == 0)
				seed = $urandom_range(1) ? 7'h7F : 7'h00;
			else
				seed = 7'($urandom);
			cfg_write(SEED_ADDR, {25'($urandom), seed});
			src_idle_pct = pick_idle_pct();
			sink_idle_pct = pick_idle_pct();
			phase_start = sent;
			paused = 0;
			while (sent - phase_start < PHASE_ITEMS) begin
				ring_segment();
				if (!paused && sent - phase_start >= PHASE_ITEMS / 2) begin
					drain();
					paused = 1;
				end
			end
		end

		drain();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		while (sent < ITEM_TARGET)
			ring_segment();

		drain();
		repeat (4) @(negedge clk);
		if (failures == 0)
			$display("led_pattern_mode_ring_test OK");
		else
			$display("led_pattern_mode_ring_test NOT OK");
		$finish;
	end

endmodule

// File: files.f
design/lpmr_pkg.sv
design/lpmr_in_if.sv
design/lpmr_out_if.sv
design/lpmr_cfg.sv
design/lpmr_core.sv
design/led_pattern_mode_ring.sv
tb/sv/led_pattern_mode_ring_test.sv
